### rtl/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// shared constants and types of the rms level pyramid
// ----------------------------------------------------------------------------
package rlp_pkg;

    localparam int SPP_W      = 16;
    localparam int LEVEL_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEV = 4'd1;

    typedef struct packed {
        logic [SPP_W-1:0]   spp;    // effective samples per point, never zero
        logic [LEVEL_W-1:0] nlev;   // effective levels in use, 1..max
    } t_cfg;

endpackage

### rtl/rms_level_pyramid_top.sv
// ----------------------------------------------------------------------------
// rms_level_pyramid_top
// multi-level rms downsampler for signed audio samples
// ----------------------------------------------------------------------------
// usage:
//  - input channel (i_in_valid / o_in_ready) takes one signed sample per word
//  - output channel (o_out_valid / i_out_ready) gives level, rms and last;
//    one sample that closes a point yields one word per cascaded level,
//    last set on the final one, a sample that closes no point yields none
//  - config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 sets
//    samples per point and restarts the partial point, index 1 sets levels
//  - front takes a new sample only after the previous square is summed,
//    and only while the queue has room
//  - back pops a point sum and divides it by samples per point, one quotient
//    bit per cycle, then runs a bit-pair square root and the output
//    handshake for each level
//  - a two-entry queue parts front and back, so samples keep flowing while a
//    result waits; when the receiver stalls the queue fills and input stalls
//  - reset clears counts, sums and level sums; no clearing pass is needed
// ----------------------------------------------------------------------------
module rms_level_pyramid_top
    import rlp_pkg::*;
#(
    parameter int MAX_LEVELS  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [LEVEL_W-1:0]     o_level,
    output logic [SAMPLE_BITS-1:0] o_rms,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // point sum width: largest square times largest point length
    localparam int SUM_W = 2 * SAMPLE_BITS - 1 + SPP_W;

    logic [SPP_W-1:0]   r_spp;
    logic [LEVEL_W-1:0] r_lev;
    t_cfg               cfg;
    logic               cfg_wr, clr;
    logic               q_push, q_pop, q_full, q_empty;
    logic [SUM_W-1:0]   q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign clr         = cfg_wr && (i_cfg_index == CFG_SPP);

    // zero means one, levels saturate at the built maximum
    assign cfg.spp  = (r_spp == '0) ? SPP_W'(1) : r_spp;
    assign cfg.nlev = (r_lev == '0) ? LEVEL_W'(1)
                    : (r_lev > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : r_lev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp <= SPP_W'(1);
            r_lev <= LEVEL_W'(1);
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_SPP) r_spp <= i_cfg_data[SPP_W-1:0];
            if (i_cfg_index == CFG_LEV) r_lev <= i_cfg_data[LEVEL_W-1:0];
        end
    end

    rlp_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_clear  (clr),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_sum    (q_wdata)
    );

    rlp_queue #(
        .W (SUM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    rlp_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_LEVELS  (MAX_LEVELS),
        .SUM_W       (SUM_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_level   (o_level),
        .o_rms     (o_rms),
        .o_last    (o_last)
    );

endmodule

### rtl/rlp_queue.sv
// ----------------------------------------------------------------------------
// rlp_queue
// two-entry queue of finished square sums between front and back
// ----------------------------------------------------------------------------
module rlp_queue
    import rlp_pkg::*;
#(
    parameter int W = 46
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

### rtl/rlp_front.sv
// ----------------------------------------------------------------------------
// rlp_front
// squares samples, accumulates them and hands finished point sums on
// ----------------------------------------------------------------------------
module rlp_front
    import rlp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 2 * SAMPLE_BITS - 1 + SPP_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_clear,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_q_full,
    output logic                   o_push,
    output logic [SUM_W-1:0]       o_sum
);

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;

    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_sq_vld, r_sq_done;
    logic [SPP_W-1:0]         r_cnt, n_cnt;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic                     acc;

    assign o_ready = !r_sq_vld && !i_q_full;
    assign acc     = i_valid && o_ready;
    assign mag     = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign prod    = mag * mag;
    assign n_cnt   = r_cnt + 1'b1;
    assign n_sum   = r_sum + {{(SUM_W-SQ_W){1'b0}}, r_sq};
    assign o_push  = r_sq_vld && r_sq_done;
    assign o_sum   = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_cnt    <= '0;
            r_sum    <= '0;
        end else if (i_clear) begin
            r_sq_vld <= 1'b0;
            r_cnt    <= '0;
            r_sum    <= '0;
        end else begin
            r_sq_vld <= acc;
            if (acc) begin
                r_cnt <= (n_cnt >= i_cfg.spp) ? '0 : n_cnt;
            end
            if (r_sq_vld) begin
                r_sum <= r_sq_done ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sq      <= prod[SQ_W-1:0];
            r_sq_done <= (n_cnt >= i_cfg.spp);
        end
    end

endmodule

### rtl/rlp_back.sv
// ----------------------------------------------------------------------------
// rlp_back
// divides point sums, takes square roots and runs the level cascade
// ----------------------------------------------------------------------------
module rlp_back
    import rlp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LEVELS  = 15,
    parameter int SUM_W       = 2 * SAMPLE_BITS - 1 + SPP_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_empty,
    input  logic [SUM_W-1:0]       i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LEVEL_W-1:0]     o_level,
    output logic [SAMPLE_BITS-1:0] o_rms,
    output logic                   o_last
);

    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int LS_W  = SQ_W + 2;
    localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int DC_W  = $clog2(SUM_W + 1);
    localparam int SC_W  = $clog2(SAMPLE_BITS + 1);
    localparam int RR_W  = SAMPLE_BITS + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]             r_st;
    logic [DC_W-1:0]        r_dcnt;
    logic [SC_W-1:0]        r_scnt;
    logic [SUM_W-1:0]       r_num;
    logic [SPP_W-1:0]       r_rem;
    logic [SQ_W-1:0]        r_mean;
    logic [2*SAMPLE_BITS-1:0] r_sx;
    logic [RR_W-1:0]        r_srem;
    logic [SAMPLE_BITS-1:0] r_root;
    logic [LEVEL_W-1:0]     r_lvl;
    logic [LS_W-1:0]        r_lsum [MAX_LEVELS];
    logic [1:0]             r_lcnt [MAX_LEVELS];

    logic [SPP_W:0]         d_t, d_s;
    logic [RR_W+1:0]        s_t, s_trial;
    logic [LEVEL_W:0]       nxt;
    logic                   nxt_ok;
    logic [IDX_W-1:0]       nidx;
    logic [LS_W-1:0]        grp_sum;
    logic                   out_last;

    // restoring divide step
    assign d_t = {r_rem, r_num[SUM_W-1]};
    assign d_s = d_t - {1'b0, i_cfg.spp};

    // square root step
    assign s_t     = {r_srem, r_sx[2*SAMPLE_BITS-1 -: 2]};
    assign s_trial = {{(RR_W-SAMPLE_BITS){1'b0}}, r_root, 2'b01};

    // cascade decision for the next level
    assign nxt      = {1'b0, r_lvl} + 1'b1;
    assign nxt_ok   = (nxt < {1'b0, i_cfg.nlev}) && (nxt < MAX_LEVELS);
    assign nidx     = nxt[IDX_W-1:0];
    assign grp_sum  = r_lsum[nidx] + {2'b00, r_mean};
    assign out_last = !nxt_ok || (r_lcnt[nidx] != 2'd3);

    assign o_pop   = (r_st == S_IDLE) && !i_q_empty;
    assign o_valid = (r_st == S_OUT);
    assign o_level = r_lvl;
    assign o_rms   = r_root;
    assign o_last  = out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            for (int k = 0; k < MAX_LEVELS; k++) begin
                r_lsum[k] <= '0;
                r_lcnt[k] <= 2'd0;
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (!i_q_empty) r_st <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt == DC_W'(SUM_W - 1)) r_st <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_scnt == SC_W'(SAMPLE_BITS - 1)) r_st <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (out_last) begin
                            r_st <= S_IDLE;
                            if (nxt_ok) begin
                                r_lsum[nidx] <= grp_sum;
                                r_lcnt[nidx] <= r_lcnt[nidx] + 2'd1;
                            end
                        end else begin
                            r_st         <= S_SQRT;
                            r_lsum[nidx] <= '0;
                            r_lcnt[nidx] <= 2'd0;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_num  <= i_q_data;
                r_rem  <= '0;
                r_dcnt <= '0;
                r_lvl  <= '0;
            end
            S_DIV: begin
                r_dcnt <= r_dcnt + 1'b1;
                if (!d_s[SPP_W]) begin
                    r_rem <= d_s[SPP_W-1:0];
                    r_num <= {r_num[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= d_t[SPP_W-1:0];
                    r_num <= {r_num[SUM_W-2:0], 1'b0};
                end
                if (r_dcnt == DC_W'(SUM_W - 1)) begin
                    r_sx   <= {1'b0, r_num[SQ_W-2:0], !d_s[SPP_W]};
                    r_mean <= {r_num[SQ_W-2:0], !d_s[SPP_W]};
                    r_srem <= '0;
                    r_root <= '0;
                    r_scnt <= '0;
                end
            end
            S_SQRT: begin
                r_scnt <= r_scnt + 1'b1;
                r_sx   <= {r_sx[2*SAMPLE_BITS-3:0], 2'b00};
                if (s_t >= s_trial) begin
                    r_srem <= RR_W'(s_t - s_trial);
                    r_root <= {r_root[SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    r_srem <= s_t[RR_W-1:0];
                    r_root <= {r_root[SAMPLE_BITS-2:0], 1'b0};
                end
            end
            S_OUT: begin
                if (i_ready && !out_last) begin
                    r_lvl  <= nxt[LEVEL_W-1:0];
                    r_mean <= grp_sum[LS_W-1:2];
                    r_sx   <= {1'b0, grp_sum[LS_W-1:2]};
                    r_srem <= '0;
                    r_root <= '0;
                    r_scnt <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule
